// File: sv/rgbtc_pkg.sv
// ----------------------------------------------------------------------------
// rgbtc_pkg
// Shared types, codes and defaults for the rgba tone curve mapper.
// ----------------------------------------------------------------------------
package rgbtc_pkg;

   // default channel width, sets table depth and arithmetic width
   localparam int CHANNEL_BITS_DEF = 8;

   // fixed widths of the transaction fields
   localparam int FIELD_W = 8;
   localparam int SEL_W   = 3;

   // command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // tone table select codes
   typedef enum logic [SEL_W-1:0] {
      TBL_MASTER = 3'd0,
      TBL_RGB    = 3'd1,
      TBL_RED    = 3'd2,
      TBL_GREEN  = 3'd3,
      TBL_BLUE   = 3'd4,
      TBL_ALPHA  = 3'd5
   } tbl_sel_type;

   // operation carried alongside the pixel data through the pipeline
   typedef struct packed {
      logic               wr;
      logic [SEL_W-1:0]   sel;
      logic [FIELD_W-1:0] idx;
      logic [FIELD_W-1:0] val;
   } op_type;

   // one finished result
   typedef struct packed {
      logic [FIELD_W-1:0] r;
      logic [FIELD_W-1:0] g;
      logic [FIELD_W-1:0] b;
      logic [FIELD_W-1:0] a;
   } res_type;

   // first-level table read by lookup lane k (red, green, blue, alpha)
   function automatic tbl_sel_type chan_table(input int k);
      tbl_sel_type t;
      case (k)
         0:       t = TBL_RED;
         1:       t = TBL_GREEN;
         2:       t = TBL_BLUE;
         default: t = TBL_ALPHA;
      endcase
      return t;
   endfunction

endpackage

// File: sv/rgbtc_ram.sv
// ----------------------------------------------------------------------------
// rgbtc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rgbtc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/rgbtc_div.sv
// ----------------------------------------------------------------------------
// rgbtc_div
// Un-premultiply pipeline: c * MAXV / a for three color channels, one
// quotient bit per stage, saturating at MAXV, bypassed for alpha 0 or full.
// ----------------------------------------------------------------------------
module rgbtc_div
   import rgbtc_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_vld,
   input  op_type                  in_op,
   input  logic [CHANNEL_BITS-1:0] in_c [0:2],
   input  logic [CHANNEL_BITS-1:0] in_a,
   output logic                    out_vld,
   output op_type                  out_op,
   output logic [CHANNEL_BITS-1:0] out_c [0:2],
   output logic [CHANNEL_BITS-1:0] out_a
);

   localparam int CB = CHANNEL_BITS;
   localparam logic [CB-1:0] MAXV = {CB{1'b1}};

   // stage 0 is the setup register, stages 1..CB each retire one bit
   logic            vld_ff  [0:CB];
   op_type          op_ff   [0:CB];
   logic [CB-1:0]   a_ff    [0:CB];
   logic [2*CB-1:0] work_ff [0:CB][0:2];
   logic            ovr_ff  [0:CB][0:2];
   logic [CB-1:0]   oval_ff [0:CB][0:2];

   logic [2*CB-1:0] work_in [0:CB][0:2];
   logic            byp;

   // setup: numerator, bypass and saturation
   assign byp = (in_a == '0) || (in_a == MAXV);

   // one restoring division step per stage
   always_comb begin
      logic [CB:0] t;
      logic        ge;
      logic [CB:0] diff;
      for (int ch = 0; ch < 3; ch++) begin
         work_in[0][ch] = {in_c[ch], {CB{1'b0}}} - {{CB{1'b0}}, in_c[ch]};
      end
      for (int s = 1; s <= CB; s++) begin
         for (int ch = 0; ch < 3; ch++) begin
            t    = {work_ff[s-1][ch][2*CB-1:CB], work_ff[s-1][ch][CB-1]};
            ge   = (t >= {1'b0, a_ff[s-1]});
            diff = ge ? (t - {1'b0, a_ff[s-1]}) : t;
            work_in[s][ch] = {diff[CB-1:0], work_ff[s-1][ch][CB-2:0], ge};
         end
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= CB; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_vld;
         for (int s = 1; s <= CB; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      op_ff[0] <= in_op;
      a_ff[0]  <= in_a;
      for (int ch = 0; ch < 3; ch++) begin
         work_ff[0][ch] <= work_in[0][ch];
         ovr_ff[0][ch]  <= byp || (in_c[ch] >= in_a);
         oval_ff[0][ch] <= byp ? in_c[ch] : MAXV;
      end
      for (int s = 1; s <= CB; s++) begin
         op_ff[s] <= op_ff[s-1];
         a_ff[s]  <= a_ff[s-1];
         for (int ch = 0; ch < 3; ch++) begin
            work_ff[s][ch] <= work_in[s][ch];
            ovr_ff[s][ch]  <= ovr_ff[s-1][ch];
            oval_ff[s][ch] <= oval_ff[s-1][ch];
         end
      end
   end

   // result select
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         out_c[ch] = ovr_ff[CB][ch] ? oval_ff[CB][ch] : work_ff[CB][ch][CB-1:0];
      end
   end

   assign out_vld = vld_ff[CB];
   assign out_op  = op_ff[CB];
   assign out_a   = a_ff[CB];

endmodule

// File: sv/rgba_tone_curve_mapper_unit.sv
// ----------------------------------------------------------------------------
// rgba_tone_curve_mapper_unit
// RGBA tone curve lookup: un-premultiply, per-channel, rgb and master tables,
// re-premultiply. Table-write transactions load one entry of one table.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while req_stall is low, pixel or table
// write, and returns one result per pixel. The pipeline runs through the
// un-premultiply divider, which retires one quotient bit per stage, followed
// by three chained table reads and the premultiply multiply. Each table is
// held in RAM copies, one for every lookup that reads it, and a write updates
// its copies as it passes the stage that reads them, so pixels and writes
// take effect in order. After reset a clearing pass zeroes all entries of
// all tables; req_stall stays high during it. Results queue in an output
// buffer, and apart from the clearing pass, input is stalled only when that
// buffer could otherwise overflow.
module rgba_tone_curve_mapper_unit
   import rgbtc_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [FIELD_W-1:0] req_red_in,
   input  logic [FIELD_W-1:0] req_green_in,
   input  logic [FIELD_W-1:0] req_blue_in,
   input  logic [FIELD_W-1:0] req_alpha_in,
   input  logic [SEL_W-1:0]   req_table_select,
   input  logic [FIELD_W-1:0] req_table_index,
   input  logic [FIELD_W-1:0] req_table_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FIELD_W-1:0] rsp_red_out,
   output logic [FIELD_W-1:0] rsp_green_out,
   output logic [FIELD_W-1:0] rsp_blue_out,
   output logic [FIELD_W-1:0] rsp_alpha_out
);

   localparam int CB         = CHANNEL_BITS;
   localparam int TBL_DEPTH  = 1 << CB;
   localparam logic [CB-1:0] MAXV = {CB{1'b1}};
   localparam logic [2*CB-1:0] HALF = {{(CB+1){1'b0}}, {(CB-1){1'b1}}};
   localparam int FIFO_DEPTH = 1 << $clog2(CB + 7);
   localparam int PW         = $clog2(FIFO_DEPTH);

   // clearing pass
   logic          clr_ff, clr_in;
   logic [CB-1:0] clr_addr_ff, clr_addr_in;

   // input handshake
   logic req_acc, pix_acc;

   // divider interface
   op_type        req_op;
   logic [CB-1:0] req_c [0:2];
   logic          dv_vld;
   op_type        dv_op;
   logic [CB-1:0] dv_c [0:2];
   logic [CB-1:0] dv_a;

   // lookup stages
   logic          l1_vld_ff;
   op_type        l1_op_ff;
   logic          l2_vld_ff;
   op_type        l2_op_ff;
   logic [CB-1:0] l2_a_ff;
   logic          l3_pix_ff;
   logic [CB-1:0] chan_addr [0:3];
   logic [CB-1:0] chan_q    [0:3];
   logic [CB-1:0] rgb_q     [0:2];
   logic [CB-1:0] mst_addr  [0:3];
   logic [CB-1:0] mst_q     [0:3];

   // premultiply stage
   logic            p1_vld_ff;
   logic [2*CB-1:0] prod_ff [0:2];
   logic [CB-1:0]   c_ff    [0:2];
   logic [CB-1:0]   a2_ff;
   res_type         res;

   // output buffer and credit
   res_type      fifo_mem [0:FIFO_DEPTH-1];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]   fifo_cnt_ff, infl_ff;
   logic          push, pop;

   // clearing pass after reset
   always_comb begin
      clr_addr_in = clr_addr_ff + 1'b1;
      clr_in      = clr_ff && (clr_addr_ff != MAXV);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // input acceptance with credit against the output buffer
   assign req_stall = clr_ff || ((infl_ff + fifo_cnt_ff) >= (PW+1)'(FIFO_DEPTH));
   assign req_acc   = req_valid && !req_stall;
   assign pix_acc   = req_acc && (req_command == CMD_PIXEL);

   always_comb begin
      req_op.wr  = (req_command == CMD_WRITE);
      req_op.sel = req_table_select;
      req_op.idx = req_table_index;
      req_op.val = req_table_value;
      req_c[0]   = CB'(req_red_in);
      req_c[1]   = CB'(req_green_in);
      req_c[2]   = CB'(req_blue_in);
   end

   // un-premultiply
   rgbtc_div #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (req_acc),
      .in_op   (req_op),
      .in_c    (req_c),
      .in_a    (CB'(req_alpha_in)),
      .out_vld (dv_vld),
      .out_op  (dv_op),
      .out_c   (dv_c),
      .out_a   (dv_a)
   );

   // first lookup: red, green, blue and alpha tables
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         chan_addr[k] = dv_c[k];
      end
      chan_addr[3] = dv_a;
   end

   for (genvar k = 0; k < 4; k++) begin : g_chan
      rgbtc_ram #(
         .WIDTH (CB),
         .DEPTH (TBL_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (clr_ff || (dv_vld && dv_op.wr && dv_op.sel == chan_table(k))),
         .wr_addr (clr_ff ? clr_addr_ff : CB'(dv_op.idx)),
         .wr_data (clr_ff ? '0 : CB'(dv_op.val)),
         .rd_addr (chan_addr[k]),
         .rd_data (chan_q[k])
      );
   end

   // second lookup: rgb table, one copy per color
   for (genvar k = 0; k < 3; k++) begin : g_rgb
      rgbtc_ram #(
         .WIDTH (CB),
         .DEPTH (TBL_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (clr_ff || (l1_vld_ff && l1_op_ff.wr && l1_op_ff.sel == TBL_RGB)),
         .wr_addr (clr_ff ? clr_addr_ff : CB'(l1_op_ff.idx)),
         .wr_data (clr_ff ? '0 : CB'(l1_op_ff.val)),
         .rd_addr (chan_q[k]),
         .rd_data (rgb_q[k])
      );
   end

   // third lookup: master table, one copy per channel
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mst_addr[k] = rgb_q[k];
      end
      mst_addr[3] = l2_a_ff;
   end

   for (genvar k = 0; k < 4; k++) begin : g_mst
      rgbtc_ram #(
         .WIDTH (CB),
         .DEPTH (TBL_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (clr_ff || (l2_vld_ff && l2_op_ff.wr && l2_op_ff.sel == TBL_MASTER)),
         .wr_addr (clr_ff ? clr_addr_ff : CB'(l2_op_ff.idx)),
         .wr_data (clr_ff ? '0 : CB'(l2_op_ff.val)),
         .rd_addr (mst_addr[k]),
         .rd_data (mst_q[k])
      );
   end

   // lookup stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         l1_vld_ff <= 1'b0;
         l2_vld_ff <= 1'b0;
         l3_pix_ff <= 1'b0;
         p1_vld_ff <= 1'b0;
      end else begin
         l1_vld_ff <= dv_vld;
         l2_vld_ff <= l1_vld_ff;
         l3_pix_ff <= l2_vld_ff && !l2_op_ff.wr;
         p1_vld_ff <= l3_pix_ff;
      end
   end

   // lookup and premultiply payload
   always_ff @(posedge clock) begin
      l1_op_ff <= dv_op;
      l2_op_ff <= l1_op_ff;
      l2_a_ff  <= chan_q[3];
      a2_ff    <= mst_q[3];
      for (int k = 0; k < 3; k++) begin
         prod_ff[k] <= mst_q[k] * mst_q[3];
         c_ff[k]    <= mst_q[k];
      end
   end

   // premultiply: rounded divide by MAXV
   always_comb begin
      logic [2*CB-1:0] x   [0:2];
      logic [2*CB:0]   sum [0:2];
      logic [CB-1:0]   q   [0:2];
      logic            byp;
      byp = (a2_ff == '0) || (a2_ff == MAXV);
      for (int k = 0; k < 3; k++) begin
         x[k]   = prod_ff[k] + HALF;
         sum[k] = {1'b0, x[k]} + {{(CB+1){1'b0}}, x[k][2*CB-1:CB]} + 1'b1;
         q[k]   = byp ? c_ff[k] : sum[k][2*CB-1:CB];
      end
      res.r = q[0][FIELD_W-1:0];
      res.g = q[1][FIELD_W-1:0];
      res.b = q[2][FIELD_W-1:0];
      res.a = a2_ff[FIELD_W-1:0];
   end

   // output buffer
   assign push = p1_vld_ff;
   assign pop  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         infl_ff     <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fifo_cnt_ff <= fifo_cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
         infl_ff     <= infl_ff + (PW+1)'(pix_acc) - (PW+1)'(push);
      end
   end

   assign rsp_valid     = (fifo_cnt_ff != '0);
   assign rsp_red_out   = fifo_mem[rd_ptr_ff].r;
   assign rsp_green_out = fifo_mem[rd_ptr_ff].g;
   assign rsp_blue_out  = fifo_mem[rd_ptr_ff].b;
   assign rsp_alpha_out = fifo_mem[rd_ptr_ff].a;

`ifndef SYNTHESIS
   // no transaction enters while the tables are being cleared
   a_no_acc_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req_acc)
      else $error("transaction accepted during clearing pass");

   // output buffer never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (fifo_cnt_ff < (PW+1)'(FIFO_DEPTH)) || pop)
      else $error("output buffer overflow");

   // credit never exceeds buffer space
   a_credit: assert property (@(posedge clock) disable iff (reset)
      (infl_ff + fifo_cnt_ff) <= (PW+1)'(FIFO_DEPTH))
      else $error("credit count beyond buffer depth");

   // a result disappears only when taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(reset) || $past(rsp_valid && !rsp_stall))
      else $error("result dropped without handshake");
`endif

endmodule
